### rtl/pot_pkg.sv
// Package: widths, register indexes and shared types for the peak-over-threshold core.
`timescale 1ns / 1ps

package pot_pkg;

    localparam int VALUE_BITS = 32;
    localparam int INDEX_BITS = 24;
    localparam int END_BITS   = INDEX_BITS + 1;
    localparam int GAP_BITS   = 16;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = (VALUE_BITS > GAP_BITS) ? VALUE_BITS : GAP_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_GAP   = 1'd1;

    // Both queues hold two entries; pointers wrap naturally at this depth.
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;
    localparam logic [QCNT_BITS-1:0] QCNT_FULL = QCNT_BITS'(QDEPTH);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [INDEX_BITS-1:0]        index;
        logic                         last;
        logic                         exceed;
    } sample_t;

    typedef struct packed {
        logic    valid;
        sample_t data;
    } item_bus_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] peak;
        logic [INDEX_BITS-1:0]        start;
        logic [END_BITS-1:0]          stop;
    } result_t;

endpackage

### rtl/pot_front.sv
// Front end: accepts samples, flags exceedances, and buffers them for the back end.
`timescale 1ns / 1ps

module pot_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [pot_pkg::VALUE_BITS-1:0] sample_value,
    input  logic [pot_pkg::INDEX_BITS-1:0]        sample_index,
    input  logic                                  partition_last,
    input  logic signed [pot_pkg::VALUE_BITS-1:0] threshold,
    output pot_pkg::item_bus_t                    item,
    input  logic                                  take
);

    pot_pkg::sample_t              buf_mem [pot_pkg::QDEPTH];
    logic [pot_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [pot_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [pot_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [pot_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [pot_pkg::QCNT_BITS-1:0] count_reg;
    logic [pot_pkg::QCNT_BITS-1:0] count_next;
    logic                          wr_en;
    logic                          rd_en;
    pot_pkg::sample_t              classified;

    always_comb
    begin
        classified.value  = sample_value;
        classified.index  = sample_index;
        classified.last   = partition_last;
        classified.exceed = (sample_value > threshold);
    end

    assign full  = (count_reg == pot_pkg::QCNT_FULL);
    assign wr_en = push && !full;
    assign rd_en = take && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_ptr_reg] <= classified;
        end
    end

    always_comb
    begin
        item.valid = (count_reg != '0);
        item.data  = buf_mem[rd_ptr_reg];
    end

endmodule

### rtl/pot_back.sv
// Back end: cluster tracking (runs declustering) and the result queue.
`timescale 1ns / 1ps

module pot_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pot_pkg::item_bus_t                    item,
    output logic                                  take,
    input  logic [pot_pkg::GAP_BITS-1:0]          min_gap,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [pot_pkg::VALUE_BITS-1:0] peak_value,
    output logic [pot_pkg::INDEX_BITS-1:0]        cluster_start,
    output logic [pot_pkg::END_BITS-1:0]          cluster_end
);

    // cluster state
    logic                                  open_reg;
    logic                                  open_next;
    logic [pot_pkg::GAP_BITS-1:0]          run_reg;
    logic [pot_pkg::GAP_BITS-1:0]          run_next;
    logic                                  hx_reg;
    logic                                  hx_next;
    logic signed [pot_pkg::VALUE_BITS-1:0] peak_reg;
    logic signed [pot_pkg::VALUE_BITS-1:0] peak_next;
    logic [pot_pkg::INDEX_BITS-1:0]        start_reg;
    logic [pot_pkg::INDEX_BITS-1:0]        start_next;
    logic [pot_pkg::END_BITS-1:0]          end_reg;
    logic [pot_pkg::END_BITS-1:0]          end_next;

    // per-item working values
    logic [pot_pkg::GAP_BITS-1:0]          run0;
    logic                                  hx0;
    logic signed [pot_pkg::VALUE_BITS-1:0] peak0;
    logic [pot_pkg::GAP_BITS-1:0]          gap;
    logic [pot_pkg::GAP_BITS-1:0]          run1;
    logic                                  hx1;
    logic signed [pot_pkg::VALUE_BITS-1:0] peak1;
    logic [pot_pkg::END_BITS-1:0]          end1;
    logic                                  close;
    logic                                  emit;
    pot_pkg::result_t                      res;

    // result queue
    pot_pkg::result_t              res_mem [pot_pkg::QDEPTH];
    logic [pot_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [pot_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [pot_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [pot_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [pot_pkg::QCNT_BITS-1:0] count_reg;
    logic [pot_pkg::QCNT_BITS-1:0] count_next;
    logic                          out_pop;
    logic                          out_push;

    assign empty   = (count_reg == '0);
    assign out_pop = pop && !empty;
    // room for a result if the queue is not full or a transaction frees a slot now
    assign take    = item.valid && ((count_reg != pot_pkg::QCNT_FULL) || out_pop);

    always_comb
    begin
        gap   = (min_gap == '0) ? pot_pkg::GAP_BITS'(1) : min_gap;
        run0  = open_reg ? run_reg : '0;
        hx0   = open_reg && hx_reg;
        peak0 = open_reg ? peak_reg : '0;
        start_next = open_reg ? start_reg : item.data.index;

        if (item.data.exceed)
        begin
            run1  = '0;
            hx1   = 1'b1;
            peak1 = (!hx0 || (item.data.value > peak0)) ? item.data.value : peak0;
            end1  = {1'b0, item.data.index} + pot_pkg::END_BITS'(1);
        end
        else
        begin
            run1  = run0 + 1'b1;
            hx1   = hx0;
            peak1 = peak0;
            end1  = end_reg;
        end

        close    = (run1 == gap) || item.data.last;
        emit     = close && hx1;
        out_push = take && emit;

        end_next = end1;
        if (close)
        begin
            open_next = 1'b0;
            run_next  = '0;
            hx_next   = 1'b0;
            peak_next = '0;
        end
        else
        begin
            open_next = 1'b1;
            run_next  = run1;
            hx_next   = hx1;
            peak_next = peak1;
        end

        res.peak  = peak1;
        res.start = start_next;
        res.stop  = end1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            run_reg   <= '0;
            hx_reg    <= 1'b0;
            peak_reg  <= '0;
            start_reg <= '0;
            end_reg   <= '0;
        end
        else if (take)
        begin
            open_reg  <= open_next;
            run_reg   <= run_next;
            hx_reg    <= hx_next;
            peak_reg  <= peak_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = out_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = out_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({out_push, out_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            res_mem[wr_ptr_reg] <= res;
        end
    end

    always_comb
    begin
        peak_value    = res_mem[rd_ptr_reg].peak;
        cluster_start = res_mem[rd_ptr_reg].start;
        cluster_end   = res_mem[rd_ptr_reg].stop;
    end

endmodule

### rtl/peak_over_threshold_declustering_core.sv
// Top level: configuration registers, front end and back end of the peak-over-threshold core.
//
//  channel   handshake           payload
//  -------   ---------           -------
//  samples   push / full         sample_value, sample_index, partition_last
//  results   empty / pop         peak_value, cluster_start, cluster_end
//  config    cfg_we              cfg_index, cfg_wdata
//
// One sample per cycle while full stays low; a result is written to the result queue
// when its closing sample is taken by the back end; each of the two queues holds two entries.
// Reset empties both queues, closes any cluster, threshold = 0, min_gap = 1.
// Back-pressure on pop fills the result queue, then the sample queue, then raises full.
`timescale 1ns / 1ps

module peak_over_threshold_declustering_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [pot_pkg::VALUE_BITS-1:0] sample_value,
    input  logic [pot_pkg::INDEX_BITS-1:0]        sample_index,
    input  logic                                  partition_last,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [pot_pkg::VALUE_BITS-1:0] peak_value,
    output logic [pot_pkg::INDEX_BITS-1:0]        cluster_start,
    output logic [pot_pkg::END_BITS-1:0]          cluster_end,
    input  logic                                  cfg_we,
    input  logic [pot_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [pot_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    logic signed [pot_pkg::VALUE_BITS-1:0] threshold_reg;
    logic [pot_pkg::GAP_BITS-1:0]          min_gap_reg;
    pot_pkg::item_bus_t                    item;
    logic                                  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            min_gap_reg   <= pot_pkg::GAP_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pot_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata[pot_pkg::VALUE_BITS-1:0];
                pot_pkg::REG_MIN_GAP:   min_gap_reg   <= cfg_wdata[pot_pkg::GAP_BITS-1:0];
                default:                ;
            endcase
        end
    end

    pot_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .sample_value   (sample_value),
        .sample_index   (sample_index),
        .partition_last (partition_last),
        .threshold      (threshold_reg),
        .item           (item),
        .take           (take)
    );

    pot_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .take          (take),
        .min_gap       (min_gap_reg),
        .empty         (empty),
        .pop           (pop),
        .peak_value    (peak_value),
        .cluster_start (cluster_start),
        .cluster_end   (cluster_end)
    );

endmodule
